>>> src/tps_pkg.sv
// Shared types and constants of the timestamp playout scheduler.
// Used by every module of the block; depends on nothing.
package tps_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned PTS_W = 63;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [CFG_W-1:0] LEAD_RST = 32'd400000000;
  localparam logic [CFG_W-1:0] RESYNC_RST = 32'd2000000000;
  localparam logic [CFG_W-1:0] CUSHION_RST = 32'd500000000;

  localparam logic [1:0] REG_LEAD = 2'd0;
  localparam logic [1:0] REG_RESYNC = 2'd1;
  localparam logic [1:0] REG_CUSHION = 2'd2;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_TICK = 3'd1,
    CMD_PAUSE = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_JUMP = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_NONE = 2'd0,
    STAT_RELEASED = 2'd1,
    STAT_FULL = 2'd2,
    STAT_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] lead;
    logic [CFG_W-1:0] resync;
    logic [CFG_W-1:0] cushion;
  } tps_cfg_t;

endpackage

>>> src/timestamp_playout_scheduler_top.sv
// Top level of the timestamp playout scheduler.
// Ties the APB register block tps_cfg to the sequencer tps_core; uses tps_pkg.
//
// Usage: one command transaction enters on in_valid/in_ready (cmd, now_ns and the
// frame fields); exactly one result transaction leaves on out_valid/out_ready
// (status, released frame, queued_count). Commands: push, tick, pause, resume,
// jump. Registers are to be written through the APB port only while no command
// is in flight; the block itself does not enforce this. One command at a time:
// in_ready is high only while the sequencer is idle and returns once the result
// is loaded into the output register. Pause, jump and rejected pushes go from
// dispatch straight to that register. A push first searches for a free slot,
// one slot per cycle. A tick runs the minimum search over the slot memory and,
// when it re-anchors, a sweep over every slot; a resume runs the sweep alone.
// Both walks run through the single read port of the slot memory and the one
// shared 64-bit adder.
// Reset (rst, synchronous) empties the queue, drops anchor and hold and loads the
// register defaults. A stalled receiver holds the result in the output register;
// the next command is accepted meanwhile, and its result waits until the held
// one is taken.
module timestamp_playout_scheduler_top
  import tps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ADDR_W-1:0]                paddr,
  input  logic [CFG_W-1:0]                 pwdata,
  output logic [CFG_W-1:0]                 prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       cmd,
  input  logic [TIME_W-1:0]                now_ns,
  input  logic [PTS_W-1:0]                 media_pts,
  input  logic                             frame_is_video,
  input  logic [2:0]                       track_number,
  input  logic [HANDLE_BITS-1:0]           frame_handle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [HANDLE_BITS-1:0]           out_handle,
  output logic                             out_is_video,
  output logic [TIME_W-1:0]                out_stamp,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queued_count
);

  tps_cfg_t cfg;

  tps_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  tps_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .now_ns(now_ns),
    .media_pts(media_pts),
    .frame_is_video(frame_is_video),
    .track_number(track_number),
    .frame_handle(frame_handle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_handle(out_handle),
    .out_is_video(out_is_video),
    .out_stamp(out_stamp),
    .queued_count(queued_count)
  );

endmodule

>>> src/tps_alu.sv
// Shared 64-bit add/subtract unit of the scheduler sequencer.
// Depends on tps_pkg for the time width.
module tps_alu
  import tps_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  input  logic              sub,
  output logic [TIME_W-1:0] sum,
  output logic              borrow
);

  logic [TIME_W:0] full;

  assign full = {1'b0, a} + {1'b0, b ^ {TIME_W{sub}}} + {{TIME_W{1'b0}}, sub};
  assign sum = full[TIME_W-1:0];
  assign borrow = sub & ~full[TIME_W];

endmodule

>>> src/tps_cfg.sv
// APB-style configuration registers: release lead, resync threshold, cushion.
// Depends on tps_pkg for the register map and the config struct.
module tps_cfg
  import tps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  output tps_cfg_t          cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lead <= LEAD_RST;
      cfg.resync <= RESYNC_RST;
      cfg.cushion <= CUSHION_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEAD: cfg.lead <= pwdata;
        REG_RESYNC: cfg.resync <= pwdata;
        REG_CUSHION: cfg.cushion <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEAD: prdata = cfg.lead;
      REG_RESYNC: prdata = cfg.resync;
      REG_CUSHION: prdata = cfg.cushion;
      default: prdata = '0;
    endcase
  end

endmodule

>>> src/tps_core.sv
// Sequencer, slot memory and valid bits of the playout scheduler.
// Depends on tps_pkg and drives the shared adder tps_alu.
module tps_core
  import tps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tps_cfg_t                       cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     cmd,
  input  logic [TIME_W-1:0]              now_ns,
  input  logic [PTS_W-1:0]               media_pts,
  input  logic                           frame_is_video,
  input  logic [2:0]                     track_number,
  input  logic [HANDLE_BITS-1:0]         frame_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [HANDLE_BITS-1:0]         out_handle,
  output logic                           out_is_video,
  output logic [TIME_W-1:0]              out_stamp,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queued_count
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = TIME_W + HANDLE_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FREE, S_ANCHOR, S_PTS_DIFF, S_STAMP, S_SCAN, S_LATE,
    S_THRESH, S_HOLD_LEN, S_BASE_ADD, S_SWEEP, S_LEAD, S_LEAD_CMP, S_RELEASE, S_FIN
  } state_t;

  state_t state;

  logic [MW-1:0] mem [QUEUE_DEPTH];
  logic [MW-1:0] mem_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  logic [MW-1:0] mem_wdata;

  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [CW-1:0]          cnt;
  logic                   anchored;
  logic [PTS_W-1:0]       first_pts;
  logic [TIME_W-1:0]      base;
  logic                   hold_active;
  logic [TIME_W-1:0]      hold_start;

  cmd_t                   cap_cmd;
  logic [TIME_W-1:0]      cap_now;
  logic [PTS_W-1:0]       cap_pts;
  logic                   cap_video;
  logic [2:0]             cap_track;
  logic [HANDLE_BITS-1:0] cap_handle;

  logic [IW-1:0]          free_idx;
  logic [CW-1:0]          rd_idx;
  logic                   rd_ok;
  logic                   chk_vld;
  logic [IW-1:0]          chk_idx;
  logic                   found;
  logic [IW-1:0]          best_idx;
  logic [TIME_W-1:0]      best_stamp;
  logic [HANDLE_BITS-1:0] best_handle;
  logic                   best_video;
  logic [TIME_W-1:0]      delta;
  logic                   late;

  status_t                res_status;
  logic [HANDLE_BITS-1:0] res_handle;
  logic                   res_video;
  logic [TIME_W-1:0]      res_stamp;

  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  logic              alu_sub;
  logic [TIME_W-1:0] alu_sum;
  logic              alu_borrow;
  logic              chk_hit;

  tps_alu u_alu (
    .a(alu_a),
    .b(alu_b),
    .sub(alu_sub),
    .sum(alu_sum),
    .borrow(alu_borrow)
  );

  assign in_ready = (state == S_IDLE);
  assign rd_ok = (rd_idx < CW'(QUEUE_DEPTH));
  assign mem_raddr = rd_ok ? rd_idx[IW-1:0] : '0;
  assign chk_hit = chk_vld & slot_valid[chk_idx];
  assign mem_we = (state == S_STAMP) || ((state == S_SWEEP) && chk_hit);
  assign mem_waddr = (state == S_STAMP) ? free_idx : chk_idx;
  assign mem_wdata = (state == S_STAMP) ? {cap_video, cap_handle, alu_sum}
                                        : {mem_q[MW-1:TIME_W], alu_sum};

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_ANCHOR: begin
        alu_a = cap_now;
        alu_b = {{(TIME_W-CFG_W){1'b0}}, cfg.cushion};
      end
      S_PTS_DIFF: begin
        alu_a = {1'b0, cap_pts};
        alu_b = {1'b0, first_pts};
        alu_sub = 1'b1;
      end
      S_STAMP, S_BASE_ADD: begin
        alu_a = base;
        alu_b = delta;
      end
      S_SCAN: begin
        alu_a = mem_q[TIME_W-1:0];
        alu_b = best_stamp;
        alu_sub = 1'b1;
      end
      S_LATE: begin
        alu_a = cap_now;
        alu_b = best_stamp;
        alu_sub = 1'b1;
      end
      S_THRESH: begin
        alu_a = {{(TIME_W-CFG_W){1'b0}}, cfg.resync};
        alu_b = delta;
        alu_sub = 1'b1;
      end
      S_HOLD_LEN: begin
        alu_a = cap_now;
        alu_b = hold_start;
        alu_sub = 1'b1;
      end
      S_SWEEP: begin
        alu_a = mem_q[TIME_W-1:0];
        alu_b = delta;
      end
      S_LEAD: begin
        alu_a = best_stamp;
        alu_b = cap_now;
        alu_sub = 1'b1;
      end
      S_LEAD_CMP: begin
        alu_a = {{(TIME_W-CFG_W){1'b0}}, cfg.lead};
        alu_b = delta;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      cnt <= '0;
      anchored <= 1'b0;
      first_pts <= '0;
      base <= '0;
      hold_active <= 1'b0;
      hold_start <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cap_cmd <= cmd_t'(cmd);
            cap_now <= now_ns;
            cap_pts <= media_pts;
            cap_video <= frame_is_video;
            cap_track <= track_number;
            cap_handle <= frame_handle;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_handle <= '0;
          res_video <= 1'b0;
          res_stamp <= '0;
          rd_idx <= '0;
          chk_vld <= 1'b0;
          found <= 1'b0;
          free_idx <= '0;
          unique case (cap_cmd)
            CMD_PUSH: begin
              if (!cap_video && cap_track != 3'd0) begin
                res_status <= STAT_DROPPED;
                state <= S_FIN;
              end else if (cnt == CW'(QUEUE_DEPTH)) begin
                res_status <= STAT_FULL;
                state <= S_FIN;
              end else begin
                res_status <= STAT_NONE;
                state <= S_FREE;
              end
            end
            CMD_TICK: begin
              res_status <= STAT_NONE;
              state <= (!hold_active && cnt != '0) ? S_SCAN : S_FIN;
            end
            CMD_PAUSE: begin
              res_status <= STAT_NONE;
              hold_active <= 1'b1;
              hold_start <= cap_now;
              state <= S_FIN;
            end
            CMD_RESUME: begin
              res_status <= STAT_NONE;
              state <= hold_active ? S_HOLD_LEN : S_FIN;
            end
            CMD_JUMP: begin
              res_status <= STAT_NONE;
              hold_active <= 1'b0;
              hold_start <= '0;
              slot_valid <= '0;
              cnt <= '0;
              anchored <= 1'b0;
              state <= S_FIN;
            end
            default: begin
              res_status <= STAT_NONE;
              state <= S_FIN;
            end
          endcase
        end
        S_FREE: begin
          if (!slot_valid[free_idx]) begin
            state <= anchored ? S_PTS_DIFF : S_ANCHOR;
          end else begin
            free_idx <= free_idx + IW'(1);
          end
        end
        S_ANCHOR: begin
          base <= alu_sum;
          first_pts <= cap_pts;
          anchored <= 1'b1;
          state <= S_PTS_DIFF;
        end
        S_PTS_DIFF: begin
          delta <= alu_sum;
          state <= S_STAMP;
        end
        S_STAMP: begin
          slot_valid[free_idx] <= 1'b1;
          cnt <= cnt + CW'(1);
          state <= S_FIN;
        end
        S_SCAN: begin
          if (rd_ok) begin
            rd_idx <= rd_idx + CW'(1);
          end
          chk_vld <= rd_ok;
          chk_idx <= mem_raddr;
          if (chk_hit && (!found || alu_borrow)) begin
            found <= 1'b1;
            best_idx <= chk_idx;
            best_stamp <= mem_q[TIME_W-1:0];
            best_handle <= mem_q[TIME_W+HANDLE_BITS-1:TIME_W];
            best_video <= mem_q[MW-1];
          end
          if (!rd_ok) begin
            state <= S_LATE;
          end
        end
        S_LATE: begin
          delta <= alu_sum;
          late <= !alu_borrow && (alu_sum != '0);
          state <= S_THRESH;
        end
        S_THRESH: begin
          state <= (late && alu_borrow) ? S_BASE_ADD : S_LEAD;
        end
        S_HOLD_LEN: begin
          delta <= alu_sum;
          hold_active <= 1'b0;
          hold_start <= '0;
          state <= S_BASE_ADD;
        end
        S_BASE_ADD: begin
          base <= alu_sum;
          rd_idx <= '0;
          chk_vld <= 1'b0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (rd_ok) begin
            rd_idx <= rd_idx + CW'(1);
          end
          chk_vld <= rd_ok;
          chk_idx <= mem_raddr;
          if (!rd_ok) begin
            if (cap_cmd == CMD_TICK) begin
              best_stamp <= cap_now;
              state <= S_RELEASE;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_LEAD: begin
          if (alu_borrow || alu_sum == '0) begin
            state <= S_RELEASE;
          end else begin
            delta <= alu_sum;
            state <= S_LEAD_CMP;
          end
        end
        S_LEAD_CMP: begin
          state <= alu_borrow ? S_FIN : S_RELEASE;
        end
        S_RELEASE: begin
          slot_valid[best_idx] <= 1'b0;
          cnt <= cnt - CW'(1);
          res_status <= STAT_RELEASED;
          res_handle <= best_handle;
          res_video <= best_video;
          res_stamp <= best_stamp;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            out_handle <= res_handle;
            out_is_video <= res_video;
            out_stamp <= res_stamp;
            queued_count <= cnt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_matches: assert property (@(posedge clk) disable iff (rst)
    cnt == CW'($countones(slot_valid)))
    else $error("held count disagrees with valid bits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH))
    else $error("held count above queue depth");

  a_release_held: assert property (@(posedge clk) disable iff (rst)
    state == S_RELEASE |-> found && slot_valid[best_idx])
    else $error("release of a slot that is not held");

  a_store_free: assert property (@(posedge clk) disable iff (rst)
    state == S_STAMP |-> !slot_valid[free_idx] && anchored)
    else $error("store into an occupied slot or without anchor");

  a_jump_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd == CMD_JUMP) |-> ##2 (cnt == '0 && !anchored && !hold_active))
    else $error("jump left frames, anchor or hold behind");

endmodule

>>> test/tps_checker.sv
`timescale 1ns / 100ps
// Checker for the timestamp playout scheduler: watches the APB port and both command
// channels, predicts each result from its own copy of the queue and registers, compares.
// Depends on tps_pkg; hands the mismatch count and the number of awaited results to tb.
module tps_checker
  import tps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [ADDR_W-1:0]                paddr,
  input  logic [CFG_W-1:0]                 pwdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [2:0]                       cmd,
  input  logic [TIME_W-1:0]                now_ns,
  input  logic [PTS_W-1:0]                 media_pts,
  input  logic                             frame_is_video,
  input  logic [2:0]                       track_number,
  input  logic [HANDLE_BITS-1:0]           frame_handle,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       status,
  input  logic [HANDLE_BITS-1:0]           out_handle,
  input  logic                             out_is_video,
  input  logic [TIME_W-1:0]                out_stamp,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queued_count,
  output int                               mismatches,
  output int                               outstanding
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    status_t                st;
    logic [HANDLE_BITS-1:0] handle;
    logic                   video;
    logic [TIME_W-1:0]      stamp;
    logic [CNT_W-1:0]       held;
  } playout_result_t;

  tps_cfg_t               cfg;
  logic                   slot_used [QUEUE_DEPTH];
  logic [TIME_W-1:0]      slot_due  [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] slot_id   [QUEUE_DEPTH];
  logic                   slot_vid  [QUEUE_DEPTH];
  logic                   locked;
  logic [PTS_W-1:0]       origin_pts;
  logic [TIME_W-1:0]      base_time;
  logic                   on_hold;
  logic [TIME_W-1:0]      hold_at;
  playout_result_t        awaited [$];
  int                     errors = 0;
  int                     awaited_n = 0;

  assign mismatches = errors;
  assign outstanding = awaited_n;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("tps_checker: %0t %s got %0h want %0h", $time, field, got, want);
  endtask

  task automatic shift_stamps(input logic [TIME_W-1:0] by);
    int i;
    base_time = base_time + by;
    for (i = 0; i < QUEUE_DEPTH; i++)
      if (slot_used[i]) slot_due[i] = slot_due[i] + by;
  endtask

  task automatic playout_step(input logic [2:0] op, input logic [TIME_W-1:0] now,
                              input logic [PTS_W-1:0] pts, input logic vid,
                              input logic [2:0] trk, input logic [HANDLE_BITS-1:0] hnd,
                              output playout_result_t r);
    int i;
    int slot;
    logic [TIME_W-1:0] due;
    r = '0;
    r.st = STAT_NONE;
    case (op)
      CMD_PUSH: begin
        if (!vid && trk != 3'd0) begin
          r.st = STAT_DROPPED;
        end else begin
          slot = QUEUE_DEPTH;
          for (i = QUEUE_DEPTH - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
          if (slot == QUEUE_DEPTH) begin
            r.st = STAT_FULL;
          end else begin
            if (!locked) begin
              locked = 1'b1;
              origin_pts = pts;
              base_time = now + TIME_W'(cfg.cushion);
            end
            slot_used[slot] = 1'b1;
            slot_due[slot] = base_time + ({1'b0, pts} - {1'b0, origin_pts});
            slot_id[slot] = hnd;
            slot_vid[slot] = vid;
          end
        end
      end
      CMD_TICK: begin
        if (!on_hold) begin
          slot = QUEUE_DEPTH;
          for (i = 0; i < QUEUE_DEPTH; i++)
            if (slot_used[i] && (slot == QUEUE_DEPTH || slot_due[i] < slot_due[slot]))
              slot = i;
          if (slot < QUEUE_DEPTH) begin
            due = slot_due[slot];
            if (due < now && now - due > TIME_W'(cfg.resync)) begin
              shift_stamps(now - due);
              due = slot_due[slot];
            end
            if (due <= now || due - now <= TIME_W'(cfg.lead)) begin
              slot_used[slot] = 1'b0;
              r.st = STAT_RELEASED;
              r.handle = slot_id[slot];
              r.video = slot_vid[slot];
              r.stamp = due;
            end
          end
        end
      end
      CMD_PAUSE: begin
        on_hold = 1'b1;
        hold_at = now;
      end
      CMD_RESUME: begin
        if (on_hold) begin
          shift_stamps(now - hold_at);
          on_hold = 1'b0;
          hold_at = '0;
        end
      end
      CMD_JUMP: begin
        on_hold = 1'b0;
        hold_at = '0;
        locked = 1'b0;
        for (i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
      end
      default: ;
    endcase
    for (i = 0; i < QUEUE_DEPTH; i++)
      if (slot_used[i]) r.held = r.held + CNT_W'(1);
  endtask

  always @(posedge clk) begin
    playout_result_t want;
    int k;
    if (rst) begin
      cfg = {LEAD_RST, RESYNC_RST, CUSHION_RST};
      for (k = 0; k < QUEUE_DEPTH; k++) begin
        slot_used[k] = 1'b0;
        slot_due[k] = '0;
        slot_id[k] = '0;
        slot_vid[k] = 1'b0;
      end
      locked = 1'b0;
      origin_pts = '0;
      base_time = '0;
      on_hold = 1'b0;
      hold_at = '0;
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_LEAD: cfg.lead = pwdata;
          REG_RESYNC: cfg.resync = pwdata;
          REG_CUSHION: cfg.cushion = pwdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected result, status", 64'(status), '0);
        end else begin
          want = awaited.pop_front();
          if (status != want.st) report_mismatch("status", 64'(status), 64'(want.st));
          if (out_handle != want.handle)
            report_mismatch("out_handle", 64'(out_handle), 64'(want.handle));
          if (out_is_video != want.video)
            report_mismatch("out_is_video", 64'(out_is_video), 64'(want.video));
          if (out_stamp != want.stamp) report_mismatch("out_stamp", out_stamp, want.stamp);
          if (queued_count != want.held)
            report_mismatch("queued_count", 64'(queued_count), 64'(want.held));
        end
      end
      if (in_valid && in_ready) begin
        playout_step(cmd, now_ns, media_pts, frame_is_video, track_number, frame_handle, want);
        awaited = {awaited, want};
      end
    end
    awaited_n = awaited.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench top for timestamp_playout_scheduler_top: clock, reset, APB register writes,
// command stimulus with random idling, result sink and verdict. Uses tps_pkg and tps_checker.
module tb;
  import tps_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [TIME_W-1:0] T0 = 64'd1_000_000_000;
  localparam logic [TIME_W-1:0] WRAP_START = 64'hFFFF_FFFF_4000_0000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 310;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [CFG_W-1:0]       pwdata;
  logic [CFG_W-1:0]       prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_ready;
  logic [2:0]             cmd;
  logic [TIME_W-1:0]      now_ns;
  logic [PTS_W-1:0]       media_pts;
  logic                   frame_is_video;
  logic [2:0]             track_number;
  logic [HANDLE_BITS-1:0] frame_handle;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_is_video;
  logic [TIME_W-1:0]      out_stamp;
  logic [CNT_W-1:0]       queued_count;
  int                     mismatches;
  int                     outstanding;

  bit                     tx_idle;
  bit                     rx_idle;
  int                     hold_req;
  int                     push_pct;
  logic [TIME_W-1:0]      wall;
  logic [PTS_W-1:0]       media_clk;

  timestamp_playout_scheduler_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .now_ns(now_ns),
    .media_pts(media_pts), .frame_is_video(frame_is_video),
    .track_number(track_number), .frame_handle(frame_handle),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .out_handle(out_handle), .out_is_video(out_is_video), .out_stamp(out_stamp),
    .queued_count(queued_count)
  );

  tps_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) playout_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .now_ns(now_ns),
    .media_pts(media_pts), .frame_is_video(frame_is_video),
    .track_number(track_number), .frame_handle(frame_handle),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .out_handle(out_handle), .out_is_video(out_is_video), .out_stamp(out_stamp),
    .queued_count(queued_count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic offer(input logic [2:0] op, input logic [TIME_W-1:0] t,
                       input logic [PTS_W-1:0] p, input logic v, input logic [2:0] tr,
                       input logic [HANDLE_BITS-1:0] h);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    now_ns <= t;
    media_pts <= p;
    frame_is_video <= v;
    track_number <= tr;
    frame_handle <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_item();
    int pick;
    logic [2:0] op;
    logic [TIME_W-1:0] t;
    logic [PTS_W-1:0] p;
    logic v;
    logic [2:0] tr;
    wall = wall + TIME_W'($urandom_range(0, 30_000_000));
    if ($urandom_range(0, 39) == 0) wall = wall + TIME_W'($urandom_range(1, 4000)) * 1_000_000;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) op = CMD_PUSH;
    else if (pick < 90) op = CMD_TICK;
    else if (pick < 94) op = CMD_PAUSE;
    else if (pick < 97) op = CMD_RESUME;
    else if (pick < 99) op = CMD_JUMP;
    else op = CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
    t = wall;
    p = media_clk;
    v = $urandom_range(0, 3) != 0;
    tr = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    if (op == CMD_PUSH) media_clk = media_clk + PTS_W'($urandom_range(0, 40_000_000));
    if ($urandom_range(0, 24) == 0) t = {$urandom, $urandom};
    if ($urandom_range(0, 24) == 0) p = PTS_W'({$urandom, $urandom});
    offer(op, t, p, v, tr, HANDLE_BITS'($urandom));
  endtask

  initial begin : sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req != 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 13) : 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    tps_cfg_t plan [PHASES];
    int ph;
    int n;
    int k;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = CMD_TICK;
    now_ns = '0;
    media_pts = '0;
    frame_is_video = 1'b0;
    track_number = '0;
    frame_handle = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 0;
    push_pct = 50;
    wall = '0;
    media_clk = '0;
    plan[0] = {32'd0, 32'd0, 32'd0};
    plan[1] = '1;
    plan[2] = {LEAD_RST, RESYNC_RST, CUSHION_RST};
    plan[3] = {$urandom, $urandom, $urandom};
    plan[4] = {32'd0, 32'hFFFF_FFFF, 32'd0};
    plan[5] = {32'hFFFF_FFFF, 32'd0, CUSHION_RST};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    offer(CMD_TICK, T0, '0, 1'b1, 3'd0, 16'h1234);
    offer(CMD_PUSH, T0, '0, 1'b0, 3'd5, 16'h5555);
    offer(CMD_PUSH, T0, '0, 1'b1, 3'd7, 16'h0001);
    offer(CMD_PUSH, T0, 63'd40_000_000, 1'b0, 3'd0, 16'h0002);
    offer(CMD_PUSH, T0, {PTS_W{1'b1}}, 1'b1, 3'd0, 16'hFFFF);
    offer(CMD_PUSH, T0, '0, 1'b1, 3'd2, 16'h0000);
    offer(CMD_TICK, T0, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_TICK, T0 + 64'd100_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_TICK, T0 + 64'd100_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_PAUSE, 64'd1_200_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_TICK, 64'd1_600_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_PAUSE, 64'd1_300_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_RESUME, 64'd1_800_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_RESUME, 64'd1_900_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_TICK, 64'd5_000_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_TICK, 64'd5_000_000_000, '0, 1'b0, 3'd0, 16'h0000);
    for (k = 0; k < 3; k++)
      offer(CMD_SPARE_FIRST + 3'(k), {$urandom, $urandom}, PTS_W'({$urandom, $urandom}),
            1'b1, 3'($urandom), HANDLE_BITS'($urandom));
    offer(CMD_JUMP, 64'd5_000_000_000, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_PUSH, {TIME_W{1'b1}}, 63'd12345, 1'b1, 3'd0, 16'hA5A5);
    offer(CMD_TICK, {TIME_W{1'b1}}, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_PUSH, '0, {PTS_W{1'b1}}, 1'b1, 3'd0, 16'h5A5A);
    offer(CMD_TICK, '0, '0, 1'b0, 3'd0, 16'h0000);
    offer(CMD_JUMP, '0, '0, 1'b0, 3'd0, 16'h0000);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_LEAD, plan[ph].lead);
      write_reg(REG_RESYNC, plan[ph].resync);
      write_reg(REG_CUSHION, plan[ph].cushion);
      if (ph == 0) write_reg(REG_SPARE, $urandom);
      wall = (ph == 2) ? WRAP_START : TIME_W'({$urandom, $urandom}) >> 4;
      media_clk = PTS_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          tx_idle = $urandom_range(0, 3) != 0;
          rx_idle = $urandom_range(0, 3) != 0;
          push_pct = $urandom_range(30, 80);
        end
        if (ph == 2 && n == 100) hold_req = 300;
        if (ph == 4 && n == 150) drain();
        send_random_item();
      end
    end

    drain();
    repeat (60) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
